@@ rtl/lbachs_pkg.sv @@
// shared widths and constants for the lba to chs converter
package lbachs_pkg;

  localparam int unsigned LbaW     = 32;
  localparam int unsigned SptW     = 6;
  localparam int unsigned HeadW    = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CylW     = 10;
  localparam int unsigned CylShift = 10;
  localparam int unsigned ProdW    = SptW + HeadW;
  localparam int unsigned LimitW   = ProdW + CylShift;
  localparam int unsigned TrackW   = CylW + HeadW;
  localparam int unsigned Latency  = LimitW + TrackW + 2;

  localparam logic [CfgIdxW-1:0] RegSpt   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeads = 2'd1;

  localparam logic [SptW-1:0]  SptReset  = 6'd63;
  localparam logic [HeadW-1:0] HeadReset = 8'd16;

  localparam logic [7:0] SatHead = 8'hFE;
  localparam logic [7:0] SatByte = 8'hFF;

  // saturation flag and sector number that ride along the head-count divider chain
  typedef struct packed {
    logic sat;
    logic [SptW-1:0] sector;
  } side_t;

endpackage

@@ rtl/lba_to_bios_chs.sv @@
// lba to packed bios cylinder/head/sector converter, top level
//
// usage: pulse start_i with block_address_i; a request is taken at every
// clock edge where start_i is high (busy_o stays low, one request per cycle).
// each request gives exactly one result: done_o is high for
// one cycle with cylinder_byte_o, head_byte_o and sector_byte_o valid.
// a request passes an input register, then the two divider chains,
// one cell per quotient bit: 24 cells for the division by sectors per track
// and 18 cells for the division by the head count, then an output register.
// results leave in request order; the receiver cannot stall, so the chain
// never holds. geometry is written through cfg_we_i / cfg_index_i /
// cfg_wdata_i (index 0 sectors per track, index 1 head count) while no
// request is in flight; other indexes are ignored.
// addresses at or above 1024 * spt * heads, or any zero geometry, give
// cylinder 0xff, head 0xfe, sector 0xff.
// reset empties the pipeline and loads 63 sectors per track, 16 heads.
module lba_to_bios_chs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [lbachs_pkg::LbaW-1:0]     block_address_i,
  input  logic                            cfg_we_i,
  input  logic [lbachs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lbachs_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic                            done_o,
  output logic [7:0]                      cylinder_byte_o,
  output logic [7:0]                      head_byte_o,
  output logic [7:0]                      sector_byte_o
);

  import lbachs_pkg::*;

  logic [SptW-1:0]   spt_q;
  logic [HeadW-1:0]  heads_q;
  logic [ProdW-1:0]  prod_q;
  logic              in_vld_q;
  logic [LbaW-1:0]   in_lba_q;
  logic              in_sat;

  logic              d1_vld;
  logic [LimitW-1:0] d1_quot;
  logic [SptW-1:0]   d1_rem;
  logic              d1_sat;
  side_t             d2_side_in;

  logic              d2_vld;
  logic [TrackW-1:0] d2_quot;
  logic [HeadW-1:0]  d2_rem;
  side_t             d2_side;

  logic [CylW-1:0]   cyl;
  logic              done_q;
  logic [7:0]        cyl_q, cyl_d;
  logic [7:0]        head_q, head_d;
  logic [7:0]        sec_q, sec_d;

  assign busy_o = 1'b0;

  // geometry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q   <= SptReset;
      heads_q <= HeadReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegSpt:   spt_q   <= cfg_wdata_i[SptW-1:0];
        RegHeads: heads_q <= cfg_wdata_i[HeadW-1:0];
        default: ;
      endcase
    end
  end

  // product is registered from the geometry and follows it in the next cycle
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(spt_q) * ProdW'(heads_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_lba_q <= block_address_i;
  end

  assign in_sat = (in_lba_q >= LbaW'({prod_q, {CylShift{1'b0}}}));

  lbachs_divider #(
    .NumW  (LimitW),
    .DivW  (SptW),
    .SideW (1)
  ) u_div_spt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_vld_q),
    .num_i     (in_lba_q[LimitW-1:0]),
    .side_i    (in_sat),
    .divisor_i (spt_q),
    .valid_o   (d1_vld),
    .quot_o    (d1_quot),
    .rem_o     (d1_rem),
    .side_o    (d1_sat)
  );

  always_comb begin
    d2_side_in.sat    = d1_sat;
    d2_side_in.sector = d1_rem + SptW'(1);
  end

  lbachs_divider #(
    .NumW  (TrackW),
    .DivW  (HeadW),
    .SideW ($bits(side_t))
  ) u_div_heads (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (d1_vld),
    .num_i     (d1_quot[TrackW-1:0]),
    .side_i    (d2_side_in),
    .divisor_i (heads_q),
    .valid_o   (d2_vld),
    .quot_o    (d2_quot),
    .rem_o     (d2_rem),
    .side_o    (d2_side)
  );

  assign cyl = d2_quot[CylW-1:0];

  always_comb begin
    if (d2_side.sat) begin
      cyl_d  = SatByte;
      head_d = SatHead;
      sec_d  = SatByte;
    end else begin
      cyl_d  = cyl[7:0];
      head_d = d2_rem;
      sec_d  = {cyl[CylW-1:8], d2_side.sector};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    cyl_q  <= cyl_d;
    head_q <= head_d;
    sec_q  <= sec_d;
  end

  assign done_o          = done_q;
  assign cylinder_byte_o = cyl_q;
  assign head_byte_o     = head_q;
  assign sector_byte_o   = sec_q;

  // every request comes out on done_o after the input register, both divider chains and the output register
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency done_o)
    else $error("request did not complete after chain latency");

  // zero geometry always saturates
  a_zero_geom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (spt_q == '0 || heads_q == '0) |->
      head_byte_o == SatHead && sector_byte_o == SatByte && cylinder_byte_o == SatByte)
    else $error("zero geometry gave an in-range result");

  // a head that is not the saturation code is below the head count
  a_head_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && head_byte_o != SatHead |-> head_byte_o < heads_q)
    else $error("head number not below head count");

  // sector numbers start at one
  a_sector_nz : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> sector_byte_o[SptW-1:0] != '0)
    else $error("sector number zero");

endmodule

@@ rtl/lbachs_div_cell.sv @@
// one restoring division step with registered outputs
module lbachs_div_cell #(
  parameter int unsigned NumW  = 24,
  parameter int unsigned DivW  = 6,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DivW-1:0]  rem_i,
  input  logic [SideW-1:0] side_i,
  input  logic [DivW-1:0]  divisor_i,
  output logic             valid_o,
  output logic [NumW-1:0]  num_o,
  output logic [DivW-1:0]  rem_o,
  output logic [SideW-1:0] side_o
);

  logic [DivW:0]    trial;
  logic [DivW:0]    diff;
  logic             ge;
  logic             valid_q;
  logic [NumW-1:0]  num_q,  num_d;
  logic [DivW-1:0]  rem_q,  rem_d;
  logic [SideW-1:0] side_q;

  always_comb begin
    trial = {rem_i, num_i[NumW-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
    rem_d = ge ? diff[DivW-1:0] : trial[DivW-1:0];
    // quotient bit enters at the bottom as dividend bits leave the top
    num_d = {num_i[NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign side_o  = side_q;

endmodule

@@ rtl/lbachs_divider.sv @@
// pipelined divider built from a chain of restoring step cells
module lbachs_divider #(
  parameter int unsigned NumW  = 24,
  parameter int unsigned DivW  = 6,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [SideW-1:0] side_i,
  input  logic [DivW-1:0]  divisor_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quot_o,
  output logic [DivW-1:0]  rem_o,
  output logic [SideW-1:0] side_o
);

  logic             vld_s  [NumW+1];
  logic [NumW-1:0]  num_s  [NumW+1];
  logic [DivW-1:0]  rem_s  [NumW+1];
  logic [SideW-1:0] side_s [NumW+1];

  assign vld_s[0]  = valid_i;
  assign num_s[0]  = num_i;
  assign rem_s[0]  = '0;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < NumW; k++) begin : g_cell
    lbachs_div_cell #(
      .NumW  (NumW),
      .DivW  (DivW),
      .SideW (SideW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vld_s[k]),
      .num_i     (num_s[k]),
      .rem_i     (rem_s[k]),
      .side_i    (side_s[k]),
      .divisor_i (divisor_i),
      .valid_o   (vld_s[k+1]),
      .num_o     (num_s[k+1]),
      .rem_o     (rem_s[k+1]),
      .side_o    (side_s[k+1])
    );
  end

  assign valid_o = vld_s[NumW];
  assign quot_o  = num_s[NumW];
  assign rem_o   = rem_s[NumW];
  assign side_o  = side_s[NumW];

endmodule
